FILE: src/pdo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pdo_pkg;

  // Store geometry
  localparam int unsigned DEPTH  = 4096;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned FILL_W = ADDR_W + 1;

  // Field widths
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned COEF_W   = 18;
  localparam int unsigned TAPS_W   = 13;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned MUL_A_W  = SAMPLE_W + 1;
  localparam int unsigned PROD_W   = MUL_A_W + COEF_W;
  localparam int unsigned SHR_W    = PROD_W - FRAC_W;
  localparam int unsigned SUM_W    = SHR_W + 1;

  // Configuration register indexes
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_LPF_FB    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LPF_IN    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_COMB_GAIN = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_TAPS      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_RING_LAST = 3'd4;

  // Request to the shared multiplier
  typedef struct packed {
    logic               en;
    logic [MUL_A_W-1:0] a;
    logic [COEF_W-1:0]  b;
  } mul_req_t;

  // Saturate a widened sum to a signed sample
  function automatic logic [SAMPLE_W-1:0] sat_sample(input logic [SUM_W-1:0] v);
    logic [SAMPLE_W-1:0] res;
    if ((&v[SUM_W-1:SAMPLE_W-1]) || !(|v[SUM_W-1:SAMPLE_W-1])) begin
      res = v[SAMPLE_W-1:0];
    end else if (v[SUM_W-1]) begin
      res = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: src/pdo_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module pdo_mul import pdo_pkg::*; (
  input  wire logic                 clk_i,
  input  wire mul_req_t             req_i,
  output logic       [PROD_W-1:0]   prod_o
);

  logic [PROD_W-1:0] prod_q;
  logic [PROD_W-1:0] prod_d;

  // Signed sample-by-coefficient product, full width
  assign prod_d = PROD_W'($signed(req_i.a) * $signed(req_i.b));

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

FILE: src/pdo_delay_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module pdo_delay_mem import pdo_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                wr_en_i,
  input  wire logic [ADDR_W-1:0]   wr_addr_i,
  input  wire logic [SAMPLE_W-1:0] wr_data_i,
  input  wire logic                rd_en_i,
  input  wire logic [ADDR_W-1:0]   rd_addr_i,
  output logic      [SAMPLE_W-1:0] rd_data_o
);

  logic [SAMPLE_W-1:0] mem_q [DEPTH];
  logic [SAMPLE_W-1:0] rd_data_q;
  logic                rd_hit_q;
  logic [FILL_W-1:0]   fill_q;
  logic [FILL_W-1:0]   fill_d;

  // Storage, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Writes always fill a prefix from entry zero, so a count marks what is valid
  always_comb begin
    fill_d = fill_q;
    if (wr_en_i && ({1'b0, wr_addr_i} >= fill_q)) begin
      fill_d = {1'b0, wr_addr_i} + FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      rd_hit_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (rd_en_i) begin
        rd_hit_q <= ({1'b0, rd_addr_i} < fill_q);
      end
    end
  end

  // Unwritten entries read as zero
  assign rd_data_o = rd_hit_q ? rd_data_q : '0;

endmodule

`default_nettype wire

FILE: src/periodic_disturbance_observer.sv
`timescale 1ns / 1ps
`default_nettype none

// Periodic disturbance observer, one error sample per request.
// Input channel: in_valid_i / in_ready_o with error_sample_i (signed Q16.16).
// Output channel: out_valid_o / out_ready_i with periodic_estimate_o,
// filtered_estimate_o and delay_error_o.
// Config: cfg_we_i writes cfg_wdata_i into register cfg_addr_i at a clock
// edge; write only while no request is in flight.
// Each request passes in order through accept, input product, sum and store
// access, gain product and output. One shared 33x18 multiplier does all three
// products in turn; a new request is taken only once the previous one has
// left the output step.
// The result sits in an output register; the next request is accepted while
// it waits. If the receiver stalls, the block holds in its final step until
// the output register frees up.
// Reset clears filter state, write index and the store fill count, so the
// delay store reads as zero without a clearing pass.

module periodic_disturbance_observer import pdo_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [COEF_W-1:0]     cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [SAMPLE_W-1:0]   error_sample_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic      [SAMPLE_W-1:0]   periodic_estimate_o,
  output logic      [SAMPLE_W-1:0]   filtered_estimate_o,
  output logic                       delay_error_o
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_MUL_IN   = 3'd1;
  localparam logic [2:0] ST_SUM      = 3'd2;
  localparam logic [2:0] ST_MUL_GAIN = 3'd3;
  localparam logic [2:0] ST_DONE     = 3'd4;

  // Configuration
  logic [COEF_W-1:0] fb_coef_q, in_coef_q, gain_q;
  logic [TAPS_W-1:0] taps_q;
  logic [ADDR_W-1:0] ring_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_coef_q   <= '0;
      in_coef_q   <= '0;
      gain_q      <= '0;
      taps_q      <= '0;
      ring_last_q <= ADDR_W'(DEPTH - 1);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_LPF_FB:    fb_coef_q   <= cfg_wdata_i;
        CFG_LPF_IN:    in_coef_q   <= cfg_wdata_i;
        CFG_COMB_GAIN: gain_q      <= cfg_wdata_i;
        CFG_TAPS:      taps_q      <= cfg_wdata_i[TAPS_W-1:0];
        CFG_RING_LAST: ring_last_q <= cfg_wdata_i[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Datapath state
  logic [2:0]          state_q, state_d;
  logic [SAMPLE_W-1:0] x_q, prev_in_q, prev_out_q, est_q;
  logic [SHR_W-1:0]    acc_q;
  logic [ADDR_W-1:0]   widx_q;
  logic                err_q, bypass_q;
  logic                out_valid_q, out_err_q;
  logic [SAMPLE_W-1:0] out_per_q, out_est_q;

  logic                in_fire, out_free;
  mul_req_t            mul_req;
  logic [PROD_W-1:0]   prod;
  logic [SHR_W-1:0]    prod_shr;
  logic [SAMPLE_W-1:0] est_d, periodic_d, delayed, rd_data;
  logic [TAPS_W:0]     diff, wrapped;
  logic                diff_neg, err_d;
  logic [ADDR_W-1:0]   rd_addr;
  logic [TAPS_W-1:0]   widx_inc;
  logic [ADDR_W-1:0]   widx_d;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign prod_shr   = prod[PROD_W-1:FRAC_W];

  // Operand selection for the shared multiplier
  always_comb begin
    mul_req = '0;
    case (state_q)
      ST_IDLE: begin
        mul_req.en = in_fire;
        mul_req.a  = {prev_out_q[SAMPLE_W-1], prev_out_q};
        mul_req.b  = fb_coef_q;
      end
      ST_MUL_IN: begin
        mul_req.en = 1'b1;
        mul_req.a  = {x_q[SAMPLE_W-1], x_q} + {prev_in_q[SAMPLE_W-1], prev_in_q};
        mul_req.b  = in_coef_q;
      end
      ST_MUL_GAIN: begin
        mul_req.en = 1'b1;
        mul_req.a  = {est_q[SAMPLE_W-1], est_q} - {delayed[SAMPLE_W-1], delayed};
        mul_req.b  = gain_q;
      end
      default: ;
    endcase
  end

  pdo_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  // Filter sum
  assign est_d = sat_sample({acc_q[SHR_W-1], acc_q} + {prod_shr[SHR_W-1], prod_shr});

  // Read address: taps back from the write index, wrapping over the ring
  assign diff     = {2'b00, widx_q} - {1'b0, taps_q};
  assign diff_neg = diff[TAPS_W];
  assign wrapped  = diff + {2'b00, ring_last_q} + (TAPS_W + 1)'(1);
  assign err_d    = diff_neg && wrapped[TAPS_W];
  assign rd_addr  = diff_neg ? wrapped[ADDR_W-1:0] : diff[ADDR_W-1:0];

  pdo_delay_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (state_q == ST_SUM),
    .wr_addr_i (widx_q),
    .wr_data_i (est_d),
    .rd_en_i   (state_q == ST_SUM),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Entry just written comes from the sum register
  assign delayed = bypass_q ? est_q : rd_data;

  // Comb output
  assign periodic_d = err_q ? '0 :
      sat_sample({{(SUM_W-SAMPLE_W){est_q[SAMPLE_W-1]}}, est_q} -
                 {prod_shr[SHR_W-1], prod_shr});

  // Write index advance
  assign widx_inc = {1'b0, widx_q} + TAPS_W'(1);
  assign widx_d   = (widx_inc > {1'b0, ring_last_q}) ? '0 : widx_inc[ADDR_W-1:0];

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_fire) state_d = ST_MUL_IN;
      ST_MUL_IN:   state_d = ST_SUM;
      ST_SUM:      state_d = ST_MUL_GAIN;
      ST_MUL_GAIN: state_d = ST_DONE;
      ST_DONE:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Control and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_in_q   <= '0;
      prev_out_q  <= '0;
      widx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
        prev_in_q   <= x_q;
        prev_out_q  <= est_q;
        widx_q      <= widx_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q <= error_sample_i;
    end
    if (state_q == ST_MUL_IN) begin
      acc_q <= prod_shr;
    end
    if (state_q == ST_SUM) begin
      est_q    <= est_d;
      err_q    <= err_d;
      bypass_q <= (rd_addr == widx_q);
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_per_q <= periodic_d;
      out_est_q <= est_q;
      out_err_q <= err_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign periodic_estimate_o = out_per_q;
  assign filtered_estimate_o = out_est_q;
  assign delay_error_o       = out_err_q;

  // Checks
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && delay_error_o) |-> (periodic_estimate_o == '0))
    else $error("periodic estimate not zero on delay error");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_fire |=> !in_ready_o)
    else $error("input taken again while a request is in flight");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result presented outside the final step");

endmodule

`default_nettype wire

FILE: test/tb_periodic_disturbance_observer.sv
`timescale 1ns / 1ps

module tb_periodic_disturbance_observer;
  import pdo_pkg::*;

  localparam longint RING_DEPTH     = DEPTH;
  localparam longint SAMPLE_MAX     = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_MIN     = -SAMPLE_MAX - 1;
  localparam int     SETTLE_CYCLES  = 12;
  localparam int     HOLDOFF_CYCLES = 300;
  localparam int     SEG_ITEMS      = 85;

  typedef struct {
    logic [SAMPLE_W-1:0] periodic;
    logic [SAMPLE_W-1:0] filtered;
    logic                err;
  } observer_result_t;

  // DUT connections
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we      = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr    = '0;
  logic [COEF_W-1:0]     cfg_wdata   = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   error_sample = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic [SAMPLE_W-1:0]   periodic_estimate;
  logic [SAMPLE_W-1:0]   filtered_estimate;
  logic                  delay_error;

  // Traffic shaping
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        holdoff_go = 1'b0;
  int unsigned holdoff_left = 0;
  logic        rx_hold;

  logic [SAMPLE_W-1:0] sample_backlog[$];
  observer_result_t    predicted_estimates[$];
  int unsigned         mismatch_count = 0;

  // Shadow of the observer state and its registers
  longint      fb_coef, in_coef, gain_coef;
  int unsigned tap_count, ring_last;
  longint      filt_prev_in, filt_prev_out;
  int unsigned wr_ptr;
  longint      delay_ring[DEPTH];

  periodic_disturbance_observer DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we),
    .cfg_addr_i          (cfg_addr),
    .cfg_wdata_i         (cfg_wdata),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .error_sample_i      (error_sample),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .periodic_estimate_o (periodic_estimate),
    .filtered_estimate_o (filtered_estimate),
    .delay_error_o       (delay_error)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Product by a Q2.16 coefficient, floored after the shift
  function automatic longint scaled_product(longint x, longint c);
    return (x * c) >>> FRAC_W;
  endfunction

  function automatic longint clamp_sample(longint v);
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    if (v < SAMPLE_MIN) return SAMPLE_MIN;
    return v;
  endfunction

  // Advance the shadow observer by one sample and return its outputs
  function automatic observer_result_t observe_sample(logic [SAMPLE_W-1:0] sample);
    observer_result_t r;
    longint x, last, idx, est, delayed;
    x = longint'($signed(sample));
    last = longint'(ring_last);
    if (last > RING_DEPTH - 1) last = RING_DEPTH - 1;
    est = clamp_sample(scaled_product(filt_prev_out, fb_coef) +
                       scaled_product(x + filt_prev_in, in_coef));
    filt_prev_in = x;
    filt_prev_out = est;
    wr_ptr = wr_ptr % DEPTH;
    delay_ring[wr_ptr] = est;
    r.err = 1'b0;
    r.periodic = '0;
    idx = longint'(wr_ptr) - longint'(tap_count);
    if (idx < 0) begin
      idx += last + 1;
      if (idx < 0) r.err = 1'b1;
    end
    if (!r.err) begin
      delayed = delay_ring[idx % RING_DEPTH];
      r.periodic = SAMPLE_W'(clamp_sample(est - scaled_product(est - delayed, gain_coef)));
    end
    wr_ptr++;
    if (longint'(wr_ptr) > last) wr_ptr = 0;
    r.filtered = est[SAMPLE_W-1:0];
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [SAMPLE_W-1:0] got,
                               logic [SAMPLE_W-1:0] want);
    $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Driver: offer backlog samples, predict on each accepted request
  always @(posedge clk_i) begin : drive_samples
    logic advance;
    advance = !in_valid;
    if (in_valid && in_ready) begin
      predicted_estimates.push_back(observe_sample(error_sample));
      advance = 1'b1;
    end
    if (advance) begin
      if (rst_ni && sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        error_sample <= sample_backlog.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk_i) begin
    if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_go) begin
      holdoff_left <= HOLDOFF_CYCLES;
    end
  end
  assign rx_hold = (holdoff_left != 0);

  // Monitor: check each accepted result against the oldest prediction
  always @(posedge clk_i) begin : check_results
    observer_result_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (predicted_estimates.size() == 0) begin
        flag_mismatch("unexpected result", periodic_estimate, '0);
      end else begin
        want = predicted_estimates.pop_front();
        if (periodic_estimate !== want.periodic)
          flag_mismatch("periodic_estimate", periodic_estimate, want.periodic);
        if (filtered_estimate !== want.filtered)
          flag_mismatch("filtered_estimate", filtered_estimate, want.filtered);
        if (delay_error !== want.err)
          flag_mismatch("delay_error", SAMPLE_W'(delay_error), SAMPLE_W'(want.err));
      end
    end
    out_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // Register write; the shadow copy follows at once since the block is idle
  task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, logic [COEF_W-1:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_LPF_FB:    fb_coef = longint'($signed(data));
      CFG_LPF_IN:    in_coef = longint'($signed(data));
      CFG_COMB_GAIN: gain_coef = longint'($signed(data));
      CFG_TAPS:      tap_count = 32'(data[TAPS_W-1:0]);
      CFG_RING_LAST: ring_last = 32'(data[ADDR_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic apply_setting(logic [COEF_W-1:0] fb, logic [COEF_W-1:0] inc,
                               logic [COEF_W-1:0] gain, logic [COEF_W-1:0] taps,
                               logic [COEF_W-1:0] ring);
    cfg_write(CFG_LPF_FB, fb);
    cfg_write(CFG_LPF_IN, inc);
    cfg_write(CFG_COMB_GAIN, gain);
    cfg_write(CFG_TAPS, taps);
    cfg_write(CFG_RING_LAST, ring);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Wait for the block to drain, then let it settle
  task automatic wait_idle();
    while (sample_backlog.size() != 0 || in_valid || predicted_estimates.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_samples(logic [SAMPLE_W-1:0] vals[$]);
    @(negedge clk_i);
    foreach (vals[i]) sample_backlog.push_back(vals[i]);
  endtask

  // Random coefficients, tap count and ring size
  task automatic random_setting();
    logic [COEF_W-1:0] fb, inc, gain, taps, ring;
    int unsigned r, ring_v, taps_v, pick;
    if ($urandom_range(1)) begin
      // stable filter: fb + 2*in = 1.0, less one LSB when r is odd
      r = $urandom_range(1, 8000);
      fb = COEF_W'(65536 - r);
      inc = COEF_W'(r / 2);
      gain = COEF_W'($urandom_range(65536));
    end else begin
      fb = COEF_W'($urandom);
      inc = COEF_W'($urandom);
      gain = COEF_W'($urandom);
    end
    pick = $urandom_range(9);
    if (pick < 4) ring_v = $urandom_range(31);
    else if (pick < 7) ring_v = $urandom_range(32, 300);
    else if (pick < 9) ring_v = DEPTH - 1;
    else ring_v = $urandom_range(DEPTH - 1);
    pick = $urandom_range(9);
    if (pick < 6) taps_v = $urandom_range(ring_v + 1);
    else if (pick < 8) taps_v = $urandom_range(ring_v + 2, 2 * ring_v + 3);
    else if (pick < 9) taps_v = $urandom_range((1 << TAPS_W) - 1);
    else taps_v = 0;
    // spare upper data bits carry noise
    taps = {COEF_W'($urandom) >> TAPS_W << TAPS_W} | COEF_W'(taps_v[TAPS_W-1:0]);
    ring = {COEF_W'($urandom) >> ADDR_W << ADDR_W} | COEF_W'(ring_v[ADDR_W-1:0]);
    apply_setting(fb, inc, gain, taps, ring);
  endtask

  // Mostly a repeating waveform with noise; some full-range and extreme samples
  task automatic random_samples(int count);
    logic [SAMPLE_W-1:0] wave[64];
    logic [SAMPLE_W-1:0] vals[$];
    int unsigned period, pick;
    period = (tap_count >= 1 && tap_count <= 64) ? tap_count : $urandom_range(1, 64);
    foreach (wave[i]) wave[i] = SAMPLE_W'($signed($urandom_range(8388607)) - 4194304);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(9);
      if (pick < 7)
        vals.push_back(wave[i % period] + SAMPLE_W'($signed($urandom_range(511)) - 256));
      else if (pick < 9)
        vals.push_back($urandom);
      else
        case ($urandom_range(3))
          0: vals.push_back(32'h7FFF_FFFF);
          1: vals.push_back(32'h8000_0000);
          2: vals.push_back(32'hFFFF_FFFF);
          default: vals.push_back(32'h0000_0000);
        endcase
    end
    queue_samples(vals);
  endtask

  // Main sequence
  initial begin
    fb_coef = 0;
    in_coef = 0;
    gain_coef = 0;
    tap_count = 0;
    ring_last = DEPTH - 1;
    filt_prev_in = 0;
    filt_prev_out = 0;
    wr_ptr = 0;
    foreach (delay_ring[i]) delay_ring[i] = 0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extreme coefficients, zero taps: delayed value is the fresh estimate
    apply_setting(18'h1FFFF, 18'h1FFFF, 18'h20000, 18'd0, 18'd4095);
    queue_samples('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000});
    wait_idle();

    // Shrink the ring below the write index: write lands there, then wraps
    apply_setting(18'(65536 - 1000), 18'd500, 18'd32768, 18'd2, 18'd3);
    queue_samples('{32'h0010_0000, 32'hFFF0_0000, 32'h1234_5678, 32'hEDCB_A988,
                    32'h0000_0000, 32'h0001_0000});
    wait_idle();

    // Tap count past the ring: error flag, zero output
    apply_setting(18'(65536 - 1000), 18'd500, 18'd32768, 18'd20, 18'd7);
    queue_samples('{32'h0040_0000, 32'hFFC0_0000, 32'h7FFF_FFFF});
    wait_idle();
    apply_setting(18'(65536 - 1000), 18'd500, 18'd32768, 18'h1FFF, 18'd4095);
    queue_samples('{32'h0002_0000, 32'h8000_0000, 32'h0000_0000});
    wait_idle();

    // Opposite extremes, single-entry ring
    apply_setting(18'h20000, 18'h20000, 18'h1FFFF, 18'd1, 18'd0);
    queue_samples('{32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                    32'h0000_0000});
    wait_idle();

    // Random part across idling modes
    for (int mode = 0; mode < 4; mode++) begin
      @(posedge clk_i);
      case (mode)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 63; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 63; end
        default: begin send_idle_pct <= 31; recv_stall_pct <= 31; end
      endcase
      for (int seg = 0; seg < 2; seg++) begin
        random_setting();
        random_samples(SEG_ITEMS);
        if (mode == 0 && seg == 0) begin
          // receiver holds off while the sender keeps offering
          random_samples(40);
          @(posedge clk_i);
          holdoff_go <= 1'b1;
          @(posedge clk_i);
          holdoff_go <= 1'b0;
        end
        wait_idle();
      end
    end

    if (predicted_estimates.size() != 0)
      flag_mismatch("results missing", '0, SAMPLE_W'(predicted_estimates.size()));
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
